### hdl/rs_parity_encoder_gf256_assert.svh
// assertion macros shared by the checker of the reed-solomon parity encoder
`ifndef RS_PARITY_ENCODER_GF256_ASSERT_SVH
`define RS_PARITY_ENCODER_GF256_ASSERT_SVH

// same-cycle implication, off while reset is held
`define RSPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rspe check failed");

// next-cycle implication, live during reset too
`define RSPE_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rspe check failed");

`endif

### hdl/rspe_pkg.sv
// package: field arithmetic, constants and cell control type of the rs parity encoder
`timescale 1ns / 1ps

package rspe_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 5;
    localparam int MAX_PARITY_DEF  = 30;
    localparam logic [CFG_W-1:0]  RESET_COUNT = 5'd10;
    localparam logic [BYTE_W-1:0] GF_POLY_LO  = 8'h1D;
    localparam int MIN_PARITY      = 2;

    // control broadcast to every cell
    typedef struct packed {
        logic init;   // clear remainder, restart generator at 1
        logic build;  // one generator step: multiply by (x + alpha^i)
        logic step;   // absorb one data item
        logic flush;  // data item is last: move remainder to shift line
        logic shift;  // parity item taken, shift line moves up
    } t_cell_ctl;

    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
        gf_xtime = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? GF_POLY_LO : '0);
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] p;
        x = a;
        p = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b[k]) begin
                p = p ^ x;
            end
            x = gf_xtime(x);
        end
        gf_mul = p;
    endfunction

endpackage

### hdl/rspe_if.sv
// stream and configuration interfaces of the rs parity encoder
`timescale 1ns / 1ps

interface rspe_data_if import rspe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_data;

    modport source (output valid, output data_byte, output last_data, input ready);
    modport sink   (input valid, input data_byte, input last_data, output ready);
endinterface

interface rspe_parity_if import rspe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] parity_byte;
    logic              last_parity;

    modport source (output valid, output parity_byte, output last_parity, input ready);
    modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

interface rspe_cfg_if import rspe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] parity_count;

    modport source (output valid, output parity_count, input ready);
    modport sink   (input valid, input parity_count, output ready);
endinterface

### hdl/rspe_cell.sv
// one lfsr cell: generator coefficient, remainder byte and parity shift byte
`timescale 1ns / 1ps

module rspe_cell import rspe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_mul_x,
    input  logic [BYTE_W-1:0] i_gen_init,
    input  logic [BYTE_W-1:0] i_gen_prev,
    input  logic [BYTE_W-1:0] i_rem_prev,
    input  logic [BYTE_W-1:0] i_sh_prev,
    output logic [BYTE_W-1:0] o_gen,
    output logic [BYTE_W-1:0] o_rem,
    output logic [BYTE_W-1:0] o_sh
);

    logic [BYTE_W-1:0] r_gen, n_gen;
    logic [BYTE_W-1:0] r_rem, n_rem;
    logic [BYTE_W-1:0] r_sh,  n_sh;
    logic [BYTE_W-1:0] w_prod;
    logic [BYTE_W-1:0] w_rem_step;

    // one multiplier: c*alpha while building, fb*g while absorbing
    assign w_prod     = gf_mul(i_mul_x, r_gen);
    assign w_rem_step = i_rem_prev ^ w_prod;

    always_comb begin
        n_gen = r_gen;
        n_rem = r_rem;
        n_sh  = r_sh;
        if (i_ctl.init) begin
            n_gen = i_gen_init;
            n_rem = '0;
        end else begin
            if (i_ctl.build) begin
                n_gen = i_gen_prev ^ w_prod;
            end
            if (i_ctl.step) begin
                n_rem = i_ctl.flush ? '0 : w_rem_step;
            end
        end
        if (i_ctl.flush) begin
            n_sh = w_rem_step;
        end else if (i_ctl.shift) begin
            n_sh = i_sh_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= i_gen_init;
            r_rem <= '0;
        end else begin
            r_gen <= n_gen;
            r_rem <= n_rem;
        end
        r_sh <= n_sh;
    end

    assign o_gen = r_gen;
    assign o_rem = r_rem;
    assign o_sh  = r_sh;

endmodule

### hdl/rs_parity_encoder_gf256.sv
// top level: systematic reed-solomon parity encoder over gf(256), poly 0x11d
`timescale 1ns / 1ps
// throughput: one data item per cycle; a data item is absorbed at the edge it is taken
// output: the first parity item shows in the cycle after the last data item is taken,
//   and all n parity items of the block go out at one per cycle while the sink is ready
// data waits while a count write is offered; a last item also while parity still drains
// reset and every parity_count write rebuild the degree-n generator (n = clamped count),
//   with data ready held low; the remainder is cleared at the same time

module rs_parity_encoder_gf256 import rspe_pkg::*; #(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rspe_data_if.sink  i_data,
    rspe_cfg_if.sink   i_cfg,
    rspe_parity_if.source o_parity
);

    // width for a count 0..MAX_PARITY and for an index 0..MAX_PARITY-1
    localparam int NW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);
    localparam int EW = (NW > CFG_W) ? NW : CFG_W;
    localparam int RESET_EFF = (int'(RESET_COUNT) < MIN_PARITY) ? MIN_PARITY :
                               (int'(RESET_COUNT) > MAX_PARITY) ? MAX_PARITY :
                               int'(RESET_COUNT);

    // control state
    logic [NW-1:0]     r_bld_left, n_bld_left;  // generator steps still to run
    logic [BYTE_W-1:0] r_alpha,    n_alpha;     // alpha^i for the current step
    logic [IW-1:0]     r_top,      n_top;       // n-1, feedback and output tap
    logic [NW-1:0]     r_cnt,      n_cnt;       // parity items left in the shift line

    logic [EW-1:0]     w_cfg_ext;
    logic [NW-1:0]     w_cfg_eff;
    logic              w_building;
    logic              w_cfg_fire;
    logic              w_in_fire;
    logic              w_out_fire;
    logic              w_line_free;
    logic [BYTE_W-1:0] w_fb;
    logic [BYTE_W-1:0] w_mul_x;
    t_cell_ctl         w_ctl;

    logic [BYTE_W-1:0] w_gen [MAX_PARITY];
    logic [BYTE_W-1:0] w_rem [MAX_PARITY];
    logic [BYTE_W-1:0] w_sh  [MAX_PARITY];

    // clamp the written count into 2..MAX_PARITY
    assign w_cfg_ext = EW'(i_cfg.parity_count);
    assign w_cfg_eff = (w_cfg_ext < EW'(MIN_PARITY)) ? NW'(MIN_PARITY) :
                       (w_cfg_ext > EW'(MAX_PARITY)) ? NW'(MAX_PARITY) :
                       NW'(w_cfg_ext);

    assign w_building = (r_bld_left != '0);

    // config only when no parity is pending so the output tap stays put
    assign i_cfg.ready = (r_cnt == '0);
    assign w_cfg_fire  = i_cfg.valid && i_cfg.ready;

    // the shift line can take a new block now or as its final item leaves
    assign w_line_free = (r_cnt == '0) || ((r_cnt == NW'(1)) && o_parity.ready);

    // a count write and a data item never share an edge
    assign i_data.ready = !w_building && !i_cfg.valid &&
                          (!i_data.last_data || w_line_free);
    assign w_in_fire    = i_data.valid && i_data.ready;

    assign o_parity.valid       = (r_cnt != '0);
    assign o_parity.parity_byte = w_sh[r_top];
    assign o_parity.last_parity = (r_cnt == NW'(1));
    assign w_out_fire           = o_parity.valid && o_parity.ready;

    // lfsr feedback from the highest remainder cell
    assign w_fb    = i_data.data_byte ^ w_rem[r_top];
    assign w_mul_x = w_building ? r_alpha : w_fb;

    always_comb begin
        w_ctl.init  = w_cfg_fire;
        w_ctl.build = w_building && !w_cfg_fire;
        w_ctl.step  = w_in_fire;
        w_ctl.flush = w_in_fire && i_data.last_data;
        w_ctl.shift = w_out_fire;
    end

    always_comb begin
        n_bld_left = r_bld_left;
        n_alpha    = r_alpha;
        n_top      = r_top;
        n_cnt      = r_cnt;
        if (w_cfg_fire) begin
            n_bld_left = w_cfg_eff;
            n_alpha    = 8'h01;
            n_top      = IW'(w_cfg_eff - NW'(1));
        end else if (w_building) begin
            n_bld_left = r_bld_left - NW'(1);
            n_alpha    = gf_xtime(r_alpha);
        end
        if (w_ctl.flush) begin
            n_cnt = NW'(r_top) + NW'(1);
        end else if (w_out_fire) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bld_left <= NW'(RESET_EFF);
            r_alpha    <= 8'h01;
            r_top      <= IW'(RESET_EFF - 1);
            r_cnt      <= '0;
        end else begin
            r_bld_left <= n_bld_left;
            r_alpha    <= n_alpha;
            r_top      <= n_top;
            r_cnt      <= n_cnt;
        end
    end

    // row of cells, cell j holds the x^j coefficient
    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        logic [BYTE_W-1:0] w_gen_prev;
        logic [BYTE_W-1:0] w_rem_prev;
        logic [BYTE_W-1:0] w_sh_prev;

        if (j == 0) begin : g_first
            assign w_gen_prev = '0;
            assign w_rem_prev = '0;
            assign w_sh_prev  = '0;
        end else begin : g_next
            assign w_gen_prev = w_gen[j-1];
            assign w_rem_prev = w_rem[j-1];
            assign w_sh_prev  = w_sh[j-1];
        end

        rspe_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_mul_x    (w_mul_x),
            .i_gen_init ((j == 0) ? 8'h01 : 8'h00),
            .i_gen_prev (w_gen_prev),
            .i_rem_prev (w_rem_prev),
            .i_sh_prev  (w_sh_prev),
            .o_gen      (w_gen[j]),
            .o_rem      (w_rem[j]),
            .o_sh       (w_sh[j])
        );
    end

endmodule

### hdl/rspe_chk.sv
// port-level checker of the rs parity encoder and its bind
`timescale 1ns / 1ps
`include "rs_parity_encoder_gf256_assert.svh"

module rspe_chk import rspe_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_last
);

    // a stalled parity item holds
    `RSPE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last))

    // reset leaves no parity pending and the generator rebuilding
    `RSPE_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid && !i_in_ready)

    // parity appears only after a last data item was taken
    `RSPE_ASSERT_IMPL(a_parity_cause, i_clk, i_rst_n, i_out_valid && !$past(i_out_valid), $past(i_in_valid && i_in_ready && i_in_last))

    // a block's parity runs without gaps until its final item
    `RSPE_ASSERT_NEXT(a_parity_burst, i_clk, i_rst_n && i_out_valid && i_out_ready && !i_out_last, !i_rst_n || i_out_valid)

endmodule

bind rs_parity_encoder_gf256 rspe_chk u_rspe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_data.valid),
    .i_in_ready  (i_data.ready),
    .i_in_last   (i_data.last_data),
    .i_out_valid (o_parity.valid),
    .i_out_ready (o_parity.ready),
    .i_out_byte  (o_parity.parity_byte),
    .i_out_last  (o_parity.last_parity)
);

### tb/tb.sv
// testbench for the reed-solomon parity encoder: directed and random blocks checked against a predictor
`timescale 1ns / 1ps

module tb import rspe_pkg::*;;

    localparam int MAXP        = MAX_PARITY_DEF;
    localparam int SETTLE      = 4;     // settle time after the expected parity has drained
    localparam int TAIL        = 40;    // quiet cycles after the last parity item
    localparam int DOG_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int HOLD_CYCLES = 300;   // long sink hold-off that backs up the data side
    localparam int RAND_ITEMS  = 290;

    // one expected parity item
    typedef struct packed {
        logic [BYTE_W-1:0] parity_byte;
        logic              last_parity;
    } parity_item_t;

    // predictor: own field tables, generator, lfsr remainder and a fifo of expected parity
    class rs_parity_calc;
        logic [CFG_W-1:0]  count_reg;
        logic [BYTE_W-1:0] gen_coef [MAXP];
        logic [BYTE_W-1:0] rem_reg [MAXP];
        logic [BYTE_W-1:0] alog_tbl [255];
        int unsigned       log_tbl [256];
        parity_item_t      pending_parity [$];
        int unsigned       mismatches;

        function new();
            logic [8:0] v;
            v = 9'd1;
            for (int i = 0; i < 255; i++) begin
                alog_tbl[i] = v[7:0];
                log_tbl[v[7:0]] = i;
                v = {v[7:0], 1'b0};
                if (v[8]) begin
                    v = v ^ 9'h11D;
                end
            end
            mismatches = 0;
            load_count(RESET_COUNT);
        endfunction

        // clamped degree of the generator
        function int unsigned degree();
            int unsigned n;
            n = 32'(count_reg);
            if (n < MIN_PARITY) n = MIN_PARITY;
            if (n > MAXP) n = MAXP;
            return n;
        endfunction

        function logic [BYTE_W-1:0] gmul(input logic [BYTE_W-1:0] a,
                                         input logic [BYTE_W-1:0] b);
            if (a == 0 || b == 0) begin
                return '0;
            end
            return alog_tbl[(log_tbl[a] + log_tbl[b]) % 255];
        endfunction

        // register write: rebuild the generator and drop any block in progress
        function void load_count(input logic [CFG_W-1:0] v);
            logic [BYTE_W-1:0] g [MAXP+1];
            int unsigned n;
            count_reg = v;
            n = degree();
            foreach (g[j]) g[j] = '0;
            g[0] = 8'd1;
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j > 0; j--) begin
                    g[j] = g[j-1] ^ gmul(g[j], alog_tbl[i]);
                end
                g[0] = gmul(g[0], alog_tbl[i]);
            end
            for (int j = 0; j < MAXP; j++) begin
                gen_coef[j] = (j < n) ? g[j] : '0;
                rem_reg[j]  = '0;
            end
        endfunction

        // one lfsr step per data item; a last item releases the remainder as parity
        function void absorb_byte(input logic [BYTE_W-1:0] d, input logic last);
            int unsigned n;
            logic [BYTE_W-1:0] fb;
            parity_item_t it;
            n  = degree();
            fb = d ^ rem_reg[n-1];
            for (int j = n - 1; j > 0; j--) begin
                rem_reg[j] = rem_reg[j-1] ^ gmul(fb, gen_coef[j]);
            end
            rem_reg[0] = gmul(fb, gen_coef[0]);
            if (last) begin
                for (int j = 0; j < n; j++) begin
                    it.parity_byte = rem_reg[n-1-j];
                    it.last_parity = (j == n - 1);
                    pending_parity.push_back(it);
                end
                foreach (rem_reg[j]) rem_reg[j] = '0;
            end
        endfunction

        function void check_parity(input logic [BYTE_W-1:0] p, input logic last);
            parity_item_t want;
            if (pending_parity.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected parity item, expected none, got %02h last %0b",
                         $time, p, last);
                return;
            end
            want = pending_parity.pop_front();
            if (p !== want.parity_byte) begin
                mismatches++;
                $display("%0t: parity_byte mismatch, expected %02h, got %02h",
                         $time, want.parity_byte, p);
            end
            if (last !== want.last_parity) begin
                mismatches++;
                $display("%0t: last_parity mismatch, expected %0b, got %0b",
                         $time, want.last_parity, last);
            end
        endfunction

        function int unsigned pending_count();
            return pending_parity.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rspe_data_if   data_ch ();
    rspe_cfg_if    cfg_ch ();
    rspe_parity_if par_ch ();

    rs_parity_encoder_gf256 DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_data   (data_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_parity (par_ch.source)
    );

    rs_parity_calc model;
    bit            idle_on;      // random gaps on both sides when set
    int unsigned   hold_len;     // request for a long sink hold-off
    int unsigned   rand_sent;

    // free-running clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // gap length: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sink side: random ready, or a long hold-off when one is requested
    always begin
        int unsigned n;
        @(negedge clk);
        if (hold_len > 0) begin
            par_ch.ready <= 1'b0;
            n = hold_len;
            hold_len = 0;
            repeat (n) @(negedge clk);
        end else begin
            n = pick_gap();
            if (n == 0) begin
                par_ch.ready <= 1'b1;
            end else begin
                par_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // monitor: every data and parity handshake is taken at the rising edge, pre-edge values
    always @(posedge clk) begin
        if (rst_n) begin
            if (par_ch.valid && par_ch.ready)
                model.check_parity(par_ch.parity_byte, par_ch.last_parity);
            if (data_ch.valid && data_ch.ready)
                model.absorb_byte(data_ch.data_byte, data_ch.last_data);
        end
    end

    // watchdog: stop when no handshake of any kind happens for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < DOG_LIMIT) begin
            @(posedge clk);
            if ((data_ch.valid && data_ch.ready) || (par_ch.valid && par_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // one data item, called and left at a falling edge; valid stays high afterwards
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic l);
        int unsigned g;
        g = pick_gap();
        if (g > 0) begin
            data_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        data_ch.valid     <= 1'b1;
        data_ch.data_byte <= b;
        data_ch.last_data <= l;
        @(posedge clk);
        while (!data_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // a block of random bytes; an abandoned block never gets its last mark
    task automatic send_block(input int unsigned len, input bit abandon);
        for (int i = 0; i < len; i++) begin
            send_item(BYTE_W'($urandom_range(0, 255)), !abandon && (i == len - 1));
            rand_sent++;
        end
    endtask

    // parity_count write, taken once the encoder accepts it with no parity pending
    task automatic write_count(input logic [CFG_W-1:0] v);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.parity_count <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        model.load_count(v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop offering data, wait for every expected parity item, then let the block settle
    task automatic wait_drained();
        data_ch.valid <= 1'b0;
        while (model.pending_count() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial begin
        int unsigned nblk;
        int unsigned r;
        logic [CFG_W-1:0] cnt;

        model     = new();
        idle_on   = 1'b1;
        hold_len  = 0;
        rand_sent = 0;

        // every input known from time zero while reset is held
        rst_n               = 1'b0;
        data_ch.valid       = 1'b0;
        data_ch.data_byte   = '0;
        data_ch.last_data   = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.parity_count = '0;
        par_ch.ready        = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset generator (n = 10): all-zero single item, then a short block of extremes
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b1);

        // count below range acts as the minimum
        wait_drained();
        write_count(5'd0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);

        // count above range acts as the maximum
        wait_drained();
        write_count(5'd31);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(8'hFF, 1'b1);

        wait_drained();
        write_count(5'd1);
        send_item(8'h7E, 1'b1);

        wait_drained();
        write_count(5'd30);
        send_item(8'h01, 1'b1);

        wait_drained();
        write_count(5'd2);
        send_item(8'hC3, 1'b0);
        send_item(8'h3C, 1'b1);

        // rewrite of the count mid-block throws the partial remainder away
        wait_drained();
        write_count(5'd10);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h56, 1'b0);
        wait_drained();
        write_count(5'd10);
        send_item(8'hA5, 1'b1);

        // long sink hold-off while short blocks keep coming: the data side must back up
        wait_drained();
        @(posedge clk);
        hold_len = HOLD_CYCLES;
        @(negedge clk);
        for (int k = 0; k < 6; k++) begin
            send_block(2, 1'b0);
        end
        rand_sent = 0;

        // random phases: new count each phase, blocks of random data, some abandoned
        while (rand_sent < RAND_ITEMS) begin
            wait_drained();
            r = $urandom_range(0, 9);
            if (r == 0)
                cnt = CFG_W'($urandom_range(0, 1));
            else if (r == 1)
                cnt = CFG_W'($urandom_range(30, 31));
            else if (r == 2)
                cnt = 5'd2;
            else
                cnt = CFG_W'($urandom_range(0, 31));
            write_count(cnt);
            idle_on = ($urandom_range(0, 3) != 0);
            nblk = $urandom_range(2, 8);
            for (int k = 0; k < nblk; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_block($urandom_range(7, 40), 1'b0);
                else
                    send_block($urandom_range(1, 6), 1'b0);
            end
            // now and then leave a block unfinished before the next count write
            if ($urandom_range(0, 7) == 0)
                send_block($urandom_range(1, 5), 1'b1);
        end

        idle_on = 1'b1;
        wait_drained();
        repeat (TAIL) @(posedge clk);

        if (model.mismatches == 0 && model.pending_count() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
